FILE: design/tcgr_pkg.sv
// shared types and constants for the text console glyph renderer
`timescale 1ns / 1ps

package tcgr_pkg;

  localparam int GLYPH_COUNT = 256;
  localparam int CELL_SIZE   = 8;
  localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
  localparam int CELL_AW     = $clog2(CELL_SIZE);
  localparam int PIX_COUNT   = CELL_SIZE * CELL_SIZE;
  localparam int PIX_AW      = $clog2(PIX_COUNT);
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int CURSOR_W = 13;
  localparam int ADDR_W   = 33;
  localparam int COLOR_W  = 24;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [7:0] CODE_NEWLINE = 8'h0A;
  localparam logic [7:0] CODE_RETURN  = 8'h0D;

  typedef enum logic {
    CMD_CHAR = 1'b0,
    CMD_LOAD = 1'b1
  } cmd_e;

  typedef enum logic [CFG_AW-1:0] {
    CFG_SCREEN_WIDTH    = 3'd0,
    CFG_SCREEN_HEIGHT   = 3'd1,
    CFG_BYTES_PER_PIXEL = 3'd2,
    CFG_LINE_PITCH      = 3'd3,
    CFG_FRAME_BASE      = 3'd4,
    CFG_FG_COLOR        = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  char_code;
    logic [63:0] glyph_bits;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  byte_address;
    logic [COLOR_W-1:0] pixel_bytes;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        screen_width;
    logic [15:0]        screen_height;
    logic [4:0]         bytes_per_pixel;
    logic [15:0]        line_pitch;
    logic [31:0]        frame_base;
    logic [COLOR_W-1:0] fg_color;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]    base;
    logic [PIX_COUNT-1:0] glyph;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: design/tcgr_front.sv
// front end: cursor, glyph store and cell base address pipeline
`timescale 1ns / 1ps

module tcgr_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tcgr_pkg::cfg_t         cfg_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tcgr_pkg::in_item_t     in_item_i,
  input  tcgr_pkg::queue_status_t q_status_i,
  output logic                   push_o,
  output tcgr_pkg::job_t         job_o
);
  import tcgr_pkg::*;

  logic [PIX_COUNT-1:0] glyph_mem [GLYPH_COUNT];
  logic [PIX_COUNT-1:0] rd_q;

  logic [CURSOR_W-1:0] col_q, col_d, row_q, row_d;
  logic [CURSOR_W-1:0] col_inc, row_inc;

  logic        s1_valid_q, s1_hit_q;
  logic [15:0] s1_px_q, s1_py_q;
  logic        s2_valid_q;
  logic [PIX_COUNT-1:0] s2_glyph_q;
  logic [31:0] s2_rowm_q;
  logic [20:0] s2_colm_q;

  logic adv, accept, is_char, in_range;
  logic [GLYPH_AW-1:0] slot;

  assign adv        = !s2_valid_q || !q_status_i.full;
  assign in_stall_o = !adv;
  assign accept     = in_valid_i && adv;
  assign is_char    = (in_item_i.cmd == CMD_CHAR) && (in_item_i.char_code != CODE_RETURN)
                      && (in_item_i.char_code != CODE_NEWLINE);
  assign in_range   = ({24'b0, in_item_i.char_code} < 32'(GLYPH_COUNT));
  assign slot       = in_item_i.char_code[GLYPH_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.cmd == CMD_LOAD && in_range) begin
      glyph_mem[slot] <= in_item_i.glyph_bits;
    end
    if (accept && is_char) begin
      rd_q <= glyph_mem[slot];
    end
  end

  // cursor moves when the transaction is taken
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    col_inc = col_q + 1'b1;
    row_inc = row_q + 1'b1;
    if (accept && in_item_i.cmd == CMD_CHAR) begin
      if (in_item_i.char_code == CODE_RETURN) begin
        col_d = '0;
      end else if (in_item_i.char_code == CODE_NEWLINE ||
                   {col_inc, 3'b000} >= cfg_i.screen_width) begin
        col_d = '0;
        row_d = ({row_inc, 3'b000} >= cfg_i.screen_height) ? '0 : row_inc;
      end else begin
        col_d = col_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (adv) begin
        s1_valid_q <= accept && is_char;
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hit_q   <= in_range;
      s1_px_q    <= {col_q, 3'b000};
      s1_py_q    <= {row_q, 3'b000};
      s2_glyph_q <= s1_hit_q ? rd_q : '0;
      s2_rowm_q  <= s1_py_q * cfg_i.line_pitch;
      s2_colm_q  <= s1_px_q * cfg_i.bytes_per_pixel;
    end
  end

  assign push_o      = s2_valid_q && !q_status_i.full;
  assign job_o.glyph = s2_glyph_q;
  assign job_o.base  = {1'b0, cfg_i.frame_base} + {1'b0, s2_rowm_q} + {12'b0, s2_colm_q};

endmodule

FILE: design/tcgr_queue.sv
// short job queue between front and back ends
`timescale 1ns / 1ps

module tcgr_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  tcgr_pkg::job_t          job_i,
  input  logic                    pop_i,
  output tcgr_pkg::job_t          job_o,
  output tcgr_pkg::queue_status_t status_o
);
  import tcgr_pkg::*;

  job_t                slots_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr_q, rptr_q;
  logic [QUEUE_AW:0]   count_q;

  function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
    next_ptr = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= next_ptr(wptr_q);
      end
      if (pop_i) begin
        rptr_q <= next_ptr(rptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= job_i;
    end
  end

  assign job_o          = slots_q[rptr_q];
  assign status_o.full  = (count_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

endmodule

FILE: design/tcgr_back.sv
// back end: expands one cell into pixel writes
`timescale 1ns / 1ps

module tcgr_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  tcgr_pkg::cfg_t          cfg_i,
  input  tcgr_pkg::job_t          job_i,
  input  tcgr_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output tcgr_pkg::out_item_t     out_item_o
);
  import tcgr_pkg::*;

  logic                 busy_q;
  logic [PIX_AW-1:0]    cnt_q;
  logic [ADDR_W-1:0]    row_addr_q, pix_addr_q, row_next;
  logic [PIX_COUNT-1:0] glyph_q;
  logic                 fire, last, row_end;

  assign last     = (cnt_q == PIX_AW'(PIX_COUNT - 1));
  assign row_end  = (cnt_q[CELL_AW-1:0] == CELL_AW'(CELL_SIZE - 1));
  assign fire     = busy_q && !out_stall_i;
  assign pop_o    = !q_status_i.empty && (!busy_q || (fire && last));
  assign row_next = row_addr_q + {17'b0, cfg_i.line_pitch};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (pop_o) begin
      busy_q <= 1'b1;
    end else if (fire && last) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cnt_q      <= '0;
      row_addr_q <= job_i.base;
      pix_addr_q <= job_i.base;
      glyph_q    <= job_i.glyph;
    end else if (fire) begin
      cnt_q   <= cnt_q + 1'b1;
      glyph_q <= {glyph_q[PIX_COUNT-2:0], 1'b0};
      if (row_end) begin
        row_addr_q <= row_next;
        pix_addr_q <= row_next;
      end else begin
        pix_addr_q <= pix_addr_q + {28'b0, cfg_i.bytes_per_pixel};
      end
    end
  end

  assign out_valid_o             = busy_q;
  assign out_item_o.byte_address = pix_addr_q;
  assign out_item_o.pixel_bytes  = glyph_q[PIX_COUNT-1] ? cfg_i.fg_color : '0;
  assign out_item_o.last         = last;

endmodule

FILE: design/text_console_glyph_renderer.sv
// top level of the text console glyph renderer
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-----------------------------
//   in      | input     | in_valid_i / in_stall_o | in_item_i (cmd, code, glyph)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (address, bytes)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// a character gives 64 pixel writes, one per unstalled cycle from the back end pixel counter
// loads, carriage return and newline give no writes
// first write passes s1, s2, the job queue and the back end, and waits behind busy cells
// reset clears cursor, queue and pipeline valids and loads register defaults
// the input stalls only when the front pipeline output meets a full queue
`timescale 1ns / 1ps

module text_console_glyph_renderer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  tcgr_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output tcgr_pkg::out_item_t   out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [2:0]            cfg_index_i,
  input  logic [31:0]           cfg_data_i
);
  import tcgr_pkg::*;

  cfg_t          cfg_q;
  job_t          push_job, pop_job;
  logic          push, pop;
  queue_status_t q_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width    <= 16'd640;
      cfg_q.screen_height   <= 16'd480;
      cfg_q.bytes_per_pixel <= 5'd3;
      cfg_q.line_pitch      <= 16'd1920;
      cfg_q.frame_base      <= 32'd0;
      cfg_q.fg_color        <= 24'hFFFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SCREEN_WIDTH:    cfg_q.screen_width    <= cfg_data_i[15:0];
        CFG_SCREEN_HEIGHT:   cfg_q.screen_height   <= cfg_data_i[15:0];
        CFG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_data_i[4:0];
        CFG_LINE_PITCH:      cfg_q.line_pitch      <= cfg_data_i[15:0];
        CFG_FRAME_BASE:      cfg_q.frame_base      <= cfg_data_i;
        CFG_FG_COLOR:        cfg_q.fg_color        <= cfg_data_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  tcgr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_status_i (q_status),
    .push_o     (push),
    .job_o      (push_job)
  );

  tcgr_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (pop_job),
    .status_o (q_status)
  );

  tcgr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_i       (pop_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_status.full))
    else $error("job queue overflow");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("job queue underflow");

  a_cell_unbroken : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_item_o.last |=> out_valid_o)
    else $error("cell writes broken before last pixel");

endmodule

FILE: bench/text_console_glyph_renderer_test.sv
// testbench for the text console glyph renderer: queued stimulus, pixel write prediction, checks
`timescale 1ns / 1ps

module text_console_glyph_renderer_test;
  import tcgr_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam longint TIMEOUT_NS = 64'd50_000_000;
  localparam int ERROR_CAP = 30;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [CFG_AW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BEAT
  } stall_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_AW-1:0] cfg_index_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  text_console_glyph_renderer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // console model
  cfg_t model_cfg;
  logic [CURSOR_W-1:0] cursor_col_m = '0;
  logic [CURSOR_W-1:0] cursor_row_m = '0;
  logic [63:0] font_m [GLYPH_COUNT];

  in_item_t pending_items[$];
  out_item_t expected_writes[$];
  bit glyph_known [GLYPH_COUNT];

  logic in_taken = 1'b0;
  bit failed = 1'b0;
  int error_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  stall_mode_e stall_mode = STALL_OFF;
  int stall_hold = 0;
  int beat_count = 0;

  function automatic void next_text_row();
    cursor_col_m = '0;
    cursor_row_m = cursor_row_m + 1'b1;
    if (32'(cursor_row_m) * CELL_SIZE >= 32'(model_cfg.screen_height)) cursor_row_m = '0;
  endfunction

  function automatic void predict_render(in_item_t it);
    logic [63:0] glyph;
    logic [63:0] pix_addr;
    out_item_t wr;
    int r;
    int c;
    if (it.cmd == CMD_LOAD) begin
      if (it.char_code < GLYPH_COUNT) font_m[it.char_code] = it.glyph_bits;
    end else if (it.char_code == CODE_RETURN) begin
      cursor_col_m = '0;
    end else if (it.char_code == CODE_NEWLINE) begin
      next_text_row();
    end else begin
      glyph = (it.char_code < GLYPH_COUNT) ? font_m[it.char_code] : '0;
      for (int p = 0; p < PIX_COUNT; p++) begin
        r = p / CELL_SIZE;
        c = p % CELL_SIZE;
        pix_addr = 64'(model_cfg.frame_base)
                 + (64'(cursor_row_m) * CELL_SIZE + r) * 64'(model_cfg.line_pitch)
                 + (64'(cursor_col_m) * CELL_SIZE + c) * 64'(model_cfg.bytes_per_pixel);
        wr.byte_address = pix_addr[ADDR_W-1:0];
        wr.pixel_bytes = glyph[PIX_COUNT-1-p] ? model_cfg.fg_color : '0;
        wr.last = (p == PIX_COUNT - 1);
        expected_writes.push_back(wr);
      end
      cursor_col_m = cursor_col_m + 1'b1;
      if (32'(cursor_col_m) * CELL_SIZE >= 32'(model_cfg.screen_width)) next_text_row();
    end
  endfunction

  function automatic void report_mismatch(string field, logic [63:0] exp_v, logic [63:0] act_v);
    failed = 1'b1;
    error_count++;
    if (error_count <= ERROR_CAP) $error("%s: expected %h, actual %h", field, exp_v, act_v);
  endfunction

  // driver: bursts of transactions with random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0 || pending_items.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_items.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          case ($urandom_range(0, 3))
            0: gap_left = 0;
            1: gap_left = $urandom_range(1, 3);
            2: gap_left = $urandom_range(4, 12);
            default: gap_left = $urandom_range(20, 70);
          endcase
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (stall_hold == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_hold = $urandom_range(50, 400);
    end else begin
      stall_hold--;
    end
    beat_count++;
    case (stall_mode)
      STALL_OFF: out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((beat_count % 9) < 4);
    endcase
  end

  // monitor
  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      in_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) predict_render(in_item_i);
      if (out_valid_o && !out_stall_i) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("unexpected byte_address", '0, 64'(out_item_o.byte_address));
        end else begin
          want = expected_writes.pop_front();
          if (out_item_o.byte_address !== want.byte_address)
            report_mismatch("byte_address", 64'(want.byte_address), 64'(out_item_o.byte_address));
          if (out_item_o.pixel_bytes !== want.pixel_bytes)
            report_mismatch("pixel_bytes", 64'(want.pixel_bytes), 64'(out_item_o.pixel_bytes));
          if (out_item_o.last !== want.last)
            report_mismatch("last", 64'(want.last), 64'(out_item_o.last));
        end
      end
    end
  end

  task automatic queue_item(cmd_e cmd, logic [7:0] code, logic [63:0] bits);
    in_item_t it;
    it.cmd = cmd;
    it.char_code = code;
    it.glyph_bits = bits;
    if (cmd == CMD_LOAD) glyph_known[code] = 1'b1;
    pending_items.push_back(it);
  endtask

  task automatic write_cfg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_SCREEN_WIDTH: model_cfg.screen_width = data[15:0];
      CFG_SCREEN_HEIGHT: model_cfg.screen_height = data[15:0];
      CFG_BYTES_PER_PIXEL: model_cfg.bytes_per_pixel = data[4:0];
      CFG_LINE_PITCH: model_cfg.line_pitch = data[15:0];
      CFG_FRAME_BASE: model_cfg.frame_base = data;
      CFG_FG_COLOR: model_cfg.fg_color = data[COLOR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // unused upper data bits carry junk
  task automatic apply_screen(logic [15:0] w, logic [15:0] h, logic [4:0] bpp,
                              logic [15:0] pitch, logic [31:0] base, logic [23:0] fg);
    logic [31:0] junk;
    junk = $urandom();
    write_cfg(CFG_SCREEN_WIDTH, {junk[31:16], w});
    write_cfg(CFG_SCREEN_HEIGHT, {junk[15:0], h});
    write_cfg(CFG_BYTES_PER_PIXEL, {junk[26:0], bpp});
    write_cfg(CFG_LINE_PITCH, {~junk[31:16], pitch});
    write_cfg(CFG_FRAME_BASE, base);
    write_cfg(CFG_FG_COLOR, {junk[7:0], fg});
  endtask

  task automatic settle_idle();
    while (pending_items.size() != 0 || in_valid_i || expected_writes.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    int unsigned sel;
    logic [7:0] code;
    logic [63:0] bits;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      case ($urandom_range(0, 4))
        0: bits = '1;
        1: bits = '0;
        2: bits = {$urandom(), $urandom()} & {$urandom(), $urandom()} & {$urandom(), $urandom()};
        default: bits = {$urandom(), $urandom()};
      endcase
      if (sel < 15) begin
        queue_item(CMD_LOAD, 8'($urandom_range(0, 255)), bits);
      end else if (sel < 22) begin
        queue_item(CMD_CHAR, CODE_RETURN, bits);
      end else if (sel < 29) begin
        queue_item(CMD_CHAR, CODE_NEWLINE, bits);
      end else begin
        do code = 8'($urandom_range(0, 255)); while (!glyph_known[code]);
        queue_item(CMD_CHAR, code, bits);
      end
    end
  endtask

  initial begin : stimulus
    model_cfg.screen_width = 16'd640;
    model_cfg.screen_height = 16'd480;
    model_cfg.bytes_per_pixel = 5'd3;
    model_cfg.line_pitch = 16'd1920;
    model_cfg.frame_base = 32'd0;
    model_cfg.fg_color = 24'hFFFFFF;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(posedge clk_i);

    // register defaults after reset
    queue_item(CMD_LOAD, 8'h41, 64'h183C_6666_7E66_6600);
    queue_item(CMD_LOAD, 8'h00, '1);
    queue_item(CMD_LOAD, 8'hFF, 64'h8000_0000_0000_0001);
    queue_item(CMD_LOAD, CODE_NEWLINE, '1);
    queue_item(CMD_LOAD, CODE_RETURN, {$urandom(), $urandom()});
    queue_item(CMD_LOAD, 8'h07, 64'hAAAA_5555_AAAA_5555);
    queue_item(CMD_LOAD, 8'h80, '0);
    queue_item(CMD_CHAR, 8'h41, '0);
    queue_item(CMD_CHAR, 8'h00, '1);
    queue_item(CMD_CHAR, 8'hFF, {$urandom(), $urandom()});
    queue_item(CMD_CHAR, CODE_RETURN, '0);
    queue_item(CMD_CHAR, 8'h07, '0);
    queue_item(CMD_CHAR, CODE_NEWLINE, '1);
    queue_item(CMD_CHAR, 8'h80, '0);
    queue_item(CMD_LOAD, 8'h41, 64'h0123_4567_89AB_CDEF);
    queue_item(CMD_CHAR, 8'h41, '0);
    queue_item(CMD_CHAR, CODE_NEWLINE, '0);
    queue_item(CMD_CHAR, CODE_RETURN, '0);
    queue_item(CMD_CHAR, 8'h00, '0);
    settle_idle();

    // tiny screen: column and row wrap
    apply_screen(16'd16, 16'd24, 5'd1, 16'd16, $urandom(), 24'($urandom()));
    repeat (7) queue_item(CMD_CHAR, 8'h41, {$urandom(), $urandom()});
    queue_random(50);
    settle_idle();

    // all registers at zero
    apply_screen('0, '0, '0, '0, '0, '0);
    queue_random(40);
    settle_idle();

    // all registers at maximum
    apply_screen('1, '1, '1, '1, '1, '1);
    queue_random(40);
    settle_idle();

    write_cfg(CFG_SPARE_LO, $urandom());
    write_cfg(CFG_SPARE_HI, $urandom());
    repeat (4) begin
      apply_screen(16'($urandom_range(0, 96)), 16'($urandom_range(0, 64)),
                   5'($urandom_range(0, 31)), 16'($urandom()), $urandom(), 24'($urandom()));
      queue_random(30);
      settle_idle();
    end

    // zero height row wrap, then largest registers: addresses pass 32 bits
    write_cfg(CFG_SCREEN_HEIGHT, 32'd0);
    queue_item(CMD_CHAR, CODE_NEWLINE, '0);
    settle_idle();
    apply_screen('1, '1, '1, '1, '1, 24'($urandom()));
    repeat (8) queue_item(CMD_CHAR, CODE_NEWLINE, {$urandom(), $urandom()});
    queue_item(CMD_LOAD, 8'h55, {$urandom(), $urandom()});
    repeat (12) queue_item(CMD_CHAR, 8'h55, {$urandom(), $urandom()});
    settle_idle();

    if (!failed && expected_writes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: text_console_glyph_renderer.f
design/tcgr_pkg.sv
design/tcgr_front.sv
design/tcgr_queue.sv
design/tcgr_back.sv
design/text_console_glyph_renderer.sv
bench/text_console_glyph_renderer_test.sv
